// File: rtl/fct_pkg.sv
// Shared types and constants for the FAT16 cluster table engine.
package fct_pkg;

  // Operation codes carried on in_func
  localparam logic [2:0] FUNC_READ    = 3'd0;
  localparam logic [2:0] FUNC_ALLOC   = 3'd1;
  localparam logic [2:0] FUNC_RESERVE = 3'd2;
  localparam logic [2:0] FUNC_COUNT   = 3'd3;
  localparam logic [2:0] FUNC_FORMAT  = 3'd4;
  localparam logic [2:0] FUNC_LOAD    = 3'd5;

  // Register index, taken from paddr[2]
  localparam logic REG_FAT_SECTORS    = 1'b0;
  localparam logic REG_TOTAL_CLUSTERS = 1'b1;

  // Entry codes
  localparam logic [15:0] ENTRY_FREE  = 16'h0000;
  localparam logic [15:0] ENTRY_END   = 16'hFFFF;
  localparam logic [15:0] ENTRY_MEDIA = 16'hFFF8;

  // First cluster that allocate may hand out
  localparam logic [12:0] FIRST_DATA_CLUSTER = 13'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_CHK,
    ST_SCAN,
    ST_FORMAT,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    FROM_ZERO,
    FROM_TWO,
    FROM_HINT
  } scan_from_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_RDATA,
    RES_HIT,
    RES_COUNT,
    RES_USABLE
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       rd_cluster;
    logic       rd_scan;
    logic       scan_init;
    scan_from_t scan_from;
    logic       end_full;
    logic       wr_cluster_end;
    logic       wr_cluster_ev;
    logic       wr_hit;
    logic       wr_format;
    logic       count_clr;
    logic       count_inc;
    logic       free_store;
    logic       alloc_fail;
    logic       res_load;
    res_sel_t   res_sel;
    logic       res_ok;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cl_in_range;
    logic free_zero;
    logic rdata_zero;
    logic pend;
    logic hit;
    logic at_end;
  } dp_sts_t;

endpackage

// File: rtl/fat16_cluster_table_engine.sv
// Top level of the FAT16 cluster table engine: configuration registers and block wiring.
//
// Usage
//   Input channel (in_valid/in_ready) carries one operation per transfer: in_func selects
//   read, allocate, reserve, count free, format or load; in_cluster and in_entry_value are
//   the operands. Every input transfer yields exactly one output transfer (out_value,
//   out_ok) on out_valid/out_ready, in order.
//   Usable clusters U = min(total_clusters, fat_sectors*256, TABLE_ENTRIES), latched when
//   an item is taken. Configuration is to be written over the APB port only while idle;
//   the user must keep to this, as the block itself does not enforce it.
// Sequencing (input transfer to result loaded into the output register)
//   read, reserve: decode, table read, check; load, out of range, unused codes: decode step
//   count: one table read per cycle over the U usable entries; allocate: scan from hint,
//   then one wrap from cluster 2; format: one table write per cycle over all entries
//   One item is in work at a time; the next is taken as soon as the sequencer is idle,
//   even while a result still waits in the output register.
// Reset
//   Hint returns to 2, free count to 0, registers to 0. The table is not cleared and holds
//   nothing defined until formatted or loaded.
// Stall
//   A stalled result holds in the output register; a finished item waits for it to drain.
module fat16_cluster_table_engine import fct_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [11:0] in_cluster,
  input  logic [15:0] in_entry_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value,
  output logic        out_ok,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]  fat_sectors_r, fat_sectors_nxt;
  logic [12:0] total_clusters_r, total_clusters_nxt;
  logic        cfg_wr;
  ctl_cmd_t    cmd;
  dp_sts_t     sts;

  // register write on the access phase; pready tied high, so no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    fat_sectors_nxt    = fat_sectors_r;
    total_clusters_nxt = total_clusters_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_FAT_SECTORS:    fat_sectors_nxt    = pwdata[4:0];
        REG_TOTAL_CLUSTERS: total_clusters_nxt = pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_sectors_r    <= '0;
      total_clusters_r <= '0;
    end else begin
      fat_sectors_r    <= fat_sectors_nxt;
      total_clusters_r <= total_clusters_nxt;
    end
  end

  // read-back
  always_comb begin
    unique case (paddr[2])
      REG_FAT_SECTORS:    prdata = 32'(fat_sectors_r);
      REG_TOTAL_CLUSTERS: prdata = 32'(total_clusters_r);
      default:            prdata = '0;
    endcase
  end

  // sequencer
  fct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, counters and result register
  fct_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cluster     (in_cluster),
    .in_entry_value (in_entry_value),
    .fat_sectors    (fat_sectors_r),
    .total_clusters (total_clusters_r),
    .out_value      (out_value),
    .out_ok         (out_ok)
  );

endmodule

// File: rtl/fct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fct_dpath.sv
// Datapath: item and limit registers, scan counter, entry table, hint, free count, result.
module fct_dpath import fct_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts,
  input  logic [11:0] in_cluster,
  input  logic [15:0] in_entry_value,
  input  logic [4:0]  fat_sectors,
  input  logic [12:0] total_clusters,
  output logic [15:0] out_value,
  output logic        out_ok
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = (AW >= 13) ? AW + 1 : 14;
  localparam logic [CW-1:0] TABLE_END = CW'(TABLE_ENTRIES);

  logic [11:0]   cl_r, cl_nxt;
  logic [15:0]   ev_r, ev_nxt;
  logic [12:0]   u_r, u_nxt;
  logic [CW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_addr_r, pend_addr_nxt;
  logic [12:0]   count_r, count_nxt;
  logic [12:0]   hint_r, hint_nxt;
  logic [12:0]   free_r, free_nxt;
  logic [15:0]   value_r, value_nxt;
  logic          ok_r, ok_nxt;

  logic [12:0]   sec_lim, u_min;
  logic [CW-1:0] u_wide, hit_next;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata, fmt_word;

  // usable clusters = min(total_clusters, fat_sectors*256, table size)
  always_comb begin
    sec_lim = 13'(fat_sectors) << 8;
    u_min   = (total_clusters < sec_lim) ? total_clusters : sec_lim;
    u_wide  = (CW'(u_min) > TABLE_END) ? TABLE_END : CW'(u_min);
  end

  // format word for the entry under the sweep counter
  always_comb begin
    if (addr_r >= CW'(u_r)) begin
      fmt_word = ENTRY_END;
    end else if (addr_r == CW'(0)) begin
      fmt_word = ENTRY_MEDIA;
    end else if (addr_r == CW'(1)) begin
      fmt_word = ENTRY_END;
    end else begin
      fmt_word = ENTRY_FREE;
    end
  end

  assign hit_next = pend_addr_r + CW'(1);

  // table ports
  always_comb begin
    ram_we    = cmd.wr_cluster_end | cmd.wr_cluster_ev | cmd.wr_hit | cmd.wr_format;
    ram_waddr = AW'(cl_r);
    ram_wdata = ENTRY_END;
    if (cmd.wr_cluster_ev) begin
      ram_wdata = ev_r;
    end else if (cmd.wr_hit) begin
      ram_waddr = pend_addr_r[AW-1:0];
    end else if (cmd.wr_format) begin
      ram_waddr = addr_r[AW-1:0];
      ram_wdata = fmt_word;
    end
    ram_re    = cmd.rd_cluster | cmd.rd_scan;
    ram_raddr = cmd.rd_cluster ? AW'(cl_r) : addr_r[AW-1:0];
  end

  fct_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cl_nxt        = cl_r;
    ev_nxt        = ev_r;
    u_nxt         = u_r;
    addr_nxt      = addr_r;
    end_nxt       = end_r;
    pend_nxt      = cmd.rd_scan;
    pend_addr_nxt = pend_addr_r;
    count_nxt     = count_r;
    hint_nxt      = hint_r;
    free_nxt      = free_r;
    value_nxt     = value_r;
    ok_nxt        = ok_r;

    if (cmd.load_item) begin
      cl_nxt = in_cluster;
      ev_nxt = in_entry_value;
      u_nxt  = u_wide[12:0];
    end

    if (cmd.scan_init) begin
      unique case (cmd.scan_from)
        FROM_ZERO: addr_nxt = '0;
        FROM_TWO:  addr_nxt = CW'(FIRST_DATA_CLUSTER);
        FROM_HINT: addr_nxt = CW'(hint_r);
        default:   addr_nxt = '0;
      endcase
      end_nxt = cmd.end_full ? TABLE_END : CW'(u_r);
    end else if (cmd.rd_scan || cmd.wr_format) begin
      addr_nxt = addr_r + CW'(1);
    end

    if (cmd.rd_scan) begin
      pend_addr_nxt = addr_r;
    end

    if (cmd.count_clr) begin
      count_nxt = '0;
    end else if (cmd.count_inc) begin
      count_nxt = count_r + 13'd1;
    end

    if (cmd.wr_hit) begin
      hint_nxt = hit_next[12:0];
    end else if (cmd.alloc_fail) begin
      hint_nxt = FIRST_DATA_CLUSTER;
    end

    if (cmd.free_store) begin
      free_nxt = count_r;
    end else if (cmd.alloc_fail) begin
      free_nxt = '0;
    end

    if (cmd.res_load) begin
      ok_nxt = cmd.res_ok;
      unique case (cmd.res_sel)
        RES_ZERO:   value_nxt = '0;
        RES_RDATA:  value_nxt = ram_rdata;
        RES_HIT:    value_nxt = 16'(pend_addr_r);
        RES_COUNT:  value_nxt = 16'(count_r);
        RES_USABLE: value_nxt = 16'(u_r);
        default:    value_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hint_r <= FIRST_DATA_CLUSTER;
      free_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      hint_r <= hint_nxt;
      free_r <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cl_r        <= cl_nxt;
    ev_r        <= ev_nxt;
    u_r         <= u_nxt;
    addr_r      <= addr_nxt;
    end_r       <= end_nxt;
    pend_addr_r <= pend_addr_nxt;
    count_r     <= count_nxt;
    value_r     <= value_nxt;
    ok_r        <= ok_nxt;
  end

  always_comb begin
    sts.cl_in_range = {1'b0, cl_r} < u_r;
    sts.free_zero   = (free_r == '0);
    sts.rdata_zero  = (ram_rdata == ENTRY_FREE);
    sts.pend        = pend_r;
    sts.hit         = pend_r && (ram_rdata == ENTRY_FREE);
    sts.at_end      = (addr_r >= end_r);
  end

  assign out_value = value_r;
  assign out_ok    = ok_r;

endmodule

// File: rtl/fct_ctrl.sv
// Controller: operation sequencing and result handshake.
module fct_ctrl import fct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_sts_t    sts,
  output ctl_cmd_t   cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  logic       pass_r, pass_nxt;
  res_sel_t   res_sel_r, res_sel_nxt;
  logic       res_ok_r, res_ok_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    pass_r    <= pass_nxt;
    res_sel_r <= res_sel_nxt;
    res_ok_r  <= res_ok_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    pass_nxt    = pass_r;
    res_sel_nxt = res_sel_r;
    res_ok_nxt  = res_ok_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.res_sel = res_sel_r;
    cmd.res_ok  = res_ok_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          func_nxt      = in_func;
          state_nxt     = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_sel_nxt = RES_ZERO;
        res_ok_nxt  = 1'b0;
        pass_nxt    = 1'b0;
        state_nxt   = ST_RESULT;
        unique case (func_r)
          FUNC_READ, FUNC_RESERVE: begin
            if (sts.cl_in_range) begin
              cmd.rd_cluster = 1'b1;
              state_nxt      = ST_RD_CHK;
            end
          end
          FUNC_LOAD: begin
            if (sts.cl_in_range) begin
              cmd.wr_cluster_ev = 1'b1;
              res_ok_nxt        = 1'b1;
            end
          end
          FUNC_ALLOC: begin
            if (!sts.free_zero) begin
              cmd.scan_init = 1'b1;
              cmd.scan_from = FROM_HINT;
              state_nxt     = ST_SCAN;
            end
          end
          FUNC_COUNT: begin
            cmd.scan_init = 1'b1;
            cmd.scan_from = FROM_ZERO;
            cmd.count_clr = 1'b1;
            state_nxt     = ST_SCAN;
          end
          FUNC_FORMAT: begin
            cmd.scan_init = 1'b1;
            cmd.scan_from = FROM_ZERO;
            cmd.end_full  = 1'b1;
            state_nxt     = ST_FORMAT;
          end
          default: begin
          end
        endcase
      end

      ST_RD_CHK: begin
        state_nxt = ST_RESULT;
        if (func_r == FUNC_READ) begin
          res_sel_nxt = RES_RDATA;
          res_ok_nxt  = 1'b1;
        end else if (sts.rdata_zero) begin
          cmd.wr_cluster_end = 1'b1;
          res_ok_nxt         = 1'b1;
        end
      end

      ST_SCAN: begin
        if (func_r == FUNC_ALLOC) begin
          if (sts.hit) begin
            cmd.wr_hit  = 1'b1;
            res_sel_nxt = RES_HIT;
            res_ok_nxt  = 1'b1;
            state_nxt   = ST_RESULT;
          end else if (sts.at_end && !sts.pend) begin
            if (!pass_r) begin
              // wrap once to the first data cluster
              cmd.scan_init = 1'b1;
              cmd.scan_from = FROM_TWO;
              pass_nxt      = 1'b1;
            end else begin
              cmd.alloc_fail = 1'b1;
              state_nxt      = ST_RESULT;
            end
          end else if (!sts.at_end) begin
            cmd.rd_scan = 1'b1;
          end
        end else begin
          cmd.count_inc = sts.hit;
          if (sts.at_end && !sts.pend) begin
            cmd.free_store = 1'b1;
            res_sel_nxt    = RES_COUNT;
            res_ok_nxt     = 1'b1;
            state_nxt      = ST_RESULT;
          end else if (!sts.at_end) begin
            cmd.rd_scan = 1'b1;
          end
        end
      end

      ST_FORMAT: begin
        if (sts.at_end) begin
          res_sel_nxt = RES_USABLE;
          res_ok_nxt  = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          cmd.wr_format = 1'b1;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: verif/fat16_cluster_table_engine_chk.sv
// Checker for the FAT16 cluster table engine: watches the channels, predicts and compares.
module fat16_cluster_table_engine_chk import fct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [11:0] in_cluster,
  input  logic [15:0] in_entry_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_value,
  input  logic        out_ok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 4096;
  localparam int MAX_PRINTED   = 100;

  typedef struct {
    logic [2:0]  func;
    logic [11:0] cluster;
    logic [15:0] value;
    logic        ok;
  } fat_result_t;

  logic [15:0] fat_copy [TABLE_ENTRIES];
  logic [12:0] alloc_hint;
  logic [12:0] free_tally;
  logic [4:0]  sectors;
  logic [12:0] clusters;
  fat_result_t due_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("%0t ns mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int usable_clusters();
    int lim;
    int u;
    lim = int'(sectors) * 256;
    u = (int'(clusters) < lim) ? int'(clusters) : lim;
    return (u > TABLE_ENTRIES) ? TABLE_ENTRIES : u;
  endfunction

  // Applies one operation to the shadow table and gives its result.
  task automatic apply_fat_op(input logic [2:0] f, input logic [11:0] cl,
                              input logic [15:0] ev, output fat_result_t r);
    int u;
    int c;
    int hit;
    int n;
    u = usable_clusters();
    r.func = f;
    r.cluster = cl;
    r.value = '0;
    r.ok = 1'b0;
    case (f)
      FUNC_READ: begin
        if (int'(cl) < u) begin
          r.value = fat_copy[cl];
          r.ok = 1'b1;
        end
      end
      FUNC_ALLOC: begin
        if (free_tally != '0) begin
          hit = -1;
          // next fit from the hint, then one wrap from the first data cluster
          for (c = int'(alloc_hint); c < u && hit < 0; c++)
            if (fat_copy[c] == ENTRY_FREE) hit = c;
          for (c = int'(FIRST_DATA_CLUSTER); c < u && hit < 0; c++)
            if (fat_copy[c] == ENTRY_FREE) hit = c;
          if (hit >= 0) begin
            fat_copy[hit] = ENTRY_END;
            alloc_hint = 13'(hit + 1);
            r.value = 16'(hit);
            r.ok = 1'b1;
          end else begin
            alloc_hint = FIRST_DATA_CLUSTER;
            free_tally = '0;
          end
        end
      end
      FUNC_RESERVE: begin
        if (int'(cl) < u && fat_copy[cl] == ENTRY_FREE) begin
          fat_copy[cl] = ENTRY_END;
          r.ok = 1'b1;
        end
      end
      FUNC_COUNT: begin
        n = 0;
        for (c = 0; c < u; c++)
          if (fat_copy[c] == ENTRY_FREE) n++;
        free_tally = 13'(n);
        r.value = 16'(n);
        r.ok = 1'b1;
      end
      FUNC_FORMAT: begin
        for (c = 0; c < u; c++) fat_copy[c] = ENTRY_FREE;
        fat_copy[0] = ENTRY_MEDIA;
        fat_copy[1] = ENTRY_END;
        // fill above the usable range wins over the two header entries
        for (c = u; c < TABLE_ENTRIES; c++) fat_copy[c] = ENTRY_END;
        r.value = 16'(u);
        r.ok = 1'b1;
      end
      FUNC_LOAD: begin
        if (int'(cl) < u) begin
          fat_copy[cl] = ev;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    fat_result_t want;
    fat_result_t fresh;
    if (!rst_n) begin
      alloc_hint = FIRST_DATA_CLUSTER;
      free_tally = '0;
      sectors = '0;
      clusters = '0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result value %h ok %b with nothing outstanding",
                                    out_value, out_ok));
        end else begin
          want = due_results.pop_front();
          if (out_value !== want.value)
            report_mismatch($sformatf("func %0d cluster %0d: value %h, want %h",
                                      want.func, want.cluster, out_value, want.value));
          if (out_ok !== want.ok)
            report_mismatch($sformatf("func %0d cluster %0d: ok %b, want %b",
                                      want.func, want.cluster, out_ok, want.ok));
        end
      end
      if (in_valid && in_ready) begin
        apply_fat_op(in_func, in_cluster, in_entry_value, fresh);
        due_results.push_back(fresh);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_FAT_SECTORS) sectors = pwdata[4:0];
        else clusters = pwdata[12:0];
      end
    end
    pending = due_results.size();
  end

endmodule

// File: verif/fat16_cluster_table_engine_tb.sv
// Testbench top for the FAT16 cluster table engine: stimulus, configuration and verdict.
module fat16_cluster_table_engine_tb import fct_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Function codes the block does not decode; they must fail without side effects
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  localparam int TABLE_ENTRIES  = 4096;
  localparam int RX_HOLD_CYCLES = 12000;  // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES  = 8;      // quiet cycles after the last result
  localparam int DRAIN_LIMIT    = 100000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_func = '0;
  logic [11:0] in_cluster = '0;
  logic [15:0] in_entry_value = '0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         in_ready;
  wire         out_valid;
  wire  [15:0] out_value;
  wire         out_ok;
  wire  [31:0] prdata;
  wire         pready;

  int fail_cnt;
  int pending_cnt;

  // Current register settings, as the stimulus knows them
  int sec_now = 0;
  int tot_now = 0;

  // Idling control: quiet flags switch off the random bursts on one side
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;

  always #4 clk = ~clk;

  fat16_cluster_table_engine dut (.*);

  fat16_cluster_table_engine_chk chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_cluster, .in_entry_value,
    .out_valid, .out_ready, .out_value, .out_ok,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors(fail_cnt), .pending(pending_cnt)
  );

  // Hard stop: the run should take well under a tenth of this
  initial begin
    #400_000_000;
    $display("simulation failed");
    $finish;
  end

  // Usable cluster count for the present settings
  function automatic int usable_now();
    int lim;
    int u;
    lim = sec_now * 256;
    u = (tot_now < lim) ? tot_now : lim;
    return (u > TABLE_ENTRIES) ? TABLE_ENTRIES : u;
  endfunction

  // One input transfer. Valid stays high into the next item unless a gap is drawn,
  // so valid is never dropped and raised again in the same step.
  task automatic send_op(input logic [2:0] f, input logic [11:0] cl, input logic [15:0] ev);
    in_valid <= 1'b1;
    in_func <= f;
    in_cluster <= cl;
    in_entry_value <= ev;
    do @(posedge clk); while (!in_ready);
    if (!tx_quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result has drained. The first edge lets the
  // checker take in a transfer made at the edge we were called on.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle completing when pready is seen
  task automatic apb_write(input logic idx, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers change only with the block idle
  task automatic configure(input int sec, input int tot);
    settle();
    apb_write(REG_FAT_SECTORS, sec);
    apb_write(REG_TOTAL_CLUSTERS, tot);
    sec_now = sec;
    tot_now = tot;
  endtask

  // Random operation: mostly in-range clusters, frees loaded often so that the
  // allocator keeps finding work, and the odd unused code.
  task automatic random_op();
    int u;
    int pick;
    int hi;
    logic [2:0]  f;
    logic [11:0] cl;
    logic [15:0] ev;
    u = usable_now();
    pick = $urandom_range(0, 99);
    if (pick < 24) f = FUNC_READ;
    else if (pick < 48) f = FUNC_ALLOC;
    else if (pick < 62) f = FUNC_RESERVE;
    else if (pick < 72) f = FUNC_COUNT;
    else if (pick < 75) f = FUNC_FORMAT;
    else if (pick < 95) f = FUNC_LOAD;
    else f = $urandom_range(0, 1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
    hi = (u + 1 > TABLE_ENTRIES - 1) ? TABLE_ENTRIES - 1 : u + 1;
    if ($urandom_range(0, 9) != 0) cl = 12'($urandom_range(0, hi));
    else cl = 12'($urandom_range(0, TABLE_ENTRIES - 1));
    pick = $urandom_range(0, 19);
    if (pick < 8) ev = ENTRY_FREE;
    else if (pick < 10) ev = ENTRY_END;
    else if (pick < 11) ev = ENTRY_MEDIA;
    else ev = 16'($urandom);
    send_op(f, cl, ev);
  endtask

  // Receiver: random ready bursts, a long hold-off on request, none when quiet
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    int guard;
    int sec;
    int tot;
    int items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- Directed part ---
    // Registers at reset give no usable clusters: every ranged operation fails,
    // allocate fails at once on the zero free count, unused codes fail.
    send_op(FUNC_READ, 12'd0, ENTRY_FREE);
    send_op(FUNC_RESERVE, 12'd4095, ENTRY_FREE);
    send_op(FUNC_LOAD, 12'd0, ENTRY_END);
    send_op(FUNC_ALLOC, 12'd0, ENTRY_FREE);
    send_op(FUNC_UNUSED_LO, 12'd0, ENTRY_FREE);
    send_op(FUNC_UNUSED_HI, 12'd4095, 16'hFFFF);
    // Format with nothing usable: the fill above the range covers the header entries
    send_op(FUNC_FORMAT, 12'd0, ENTRY_FREE);
    send_op(FUNC_COUNT, 12'd0, ENTRY_FREE);

    configure(1, 12);
    send_op(FUNC_READ, 12'd0, ENTRY_FREE);        // still the end marker from the fill
    send_op(FUNC_FORMAT, 12'd0, ENTRY_FREE);
    send_op(FUNC_COUNT, 12'd0, ENTRY_FREE);
    send_op(FUNC_READ, 12'd0, ENTRY_FREE);        // media entry
    send_op(FUNC_READ, 12'd12, ENTRY_FREE);       // first cluster past the range
    send_op(FUNC_RESERVE, 12'd5, ENTRY_FREE);
    send_op(FUNC_RESERVE, 12'd5, ENTRY_FREE);     // no longer free
    send_op(FUNC_LOAD, 12'd11, 16'hFFFF);
    send_op(FUNC_LOAD, 12'd3, 16'h0000);
    // Allocate through the range, wrap to cluster 2, run out, then fail at once
    repeat (10) send_op(FUNC_ALLOC, 12'd0, ENTRY_FREE);
    send_op(FUNC_LOAD, 12'd4095, 16'h5A5A);
    send_op(FUNC_COUNT, 12'd0, ENTRY_FREE);

    // --- Random part: phases with their own register settings ---
    for (int p = 0; p < 14; p++) begin
      case (p)
        2: begin sec = 31; tot = 8191; items = 12; end  // every register bit set
        5: begin sec = 16; tot = 4096; items = 12; end  // full-size table
        7: begin sec = 0; tot = 4096; items = 20; end   // no sectors at all
        9: begin sec = 2; tot = 1; items = 20; end      // one usable cluster
        default: begin
          sec = $urandom_range(1, 3);
          tot = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 700)
                                            : $urandom_range(2, 40);
          items = 36;
        end
      endcase
      configure(sec, tot);
      // Most phases start from a fresh table; the rest keep what the last one left
      if ($urandom_range(0, 3) != 0) send_op(FUNC_FORMAT, 12'd0, ENTRY_FREE);
      send_op(FUNC_COUNT, 12'd0, ENTRY_FREE);
      if (p == 1) begin
        // Receiver holds off while the sender keeps offering: the block fills and stalls
        rx_hold_req = 1'b1;
        tx_quiet = 1'b1;
        repeat (14) random_op();
        tx_quiet = 1'b0;
      end
      for (int i = 0; i < items; i++) begin
        if (p == 4 && i == items / 2) settle();  // sender pause until all results are in
        random_op();
      end
    end

    // Closing stretch with no idling on either side
    configure(1, 30);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_op(FUNC_FORMAT, 12'd0, ENTRY_FREE);
    send_op(FUNC_COUNT, 12'd0, ENTRY_FREE);
    repeat (40) random_op();

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending_cnt != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
